// ===== sv/des_pkg.sv =====
// des_pkg: constants, tables and helper functions for the des block cipher core
// no dependencies
package des_pkg;

    localparam int RoundCount = 16;

    typedef logic [63:0] block_t;
    typedef logic [47:0] subkey_t;
    typedef logic [27:0] half_key_t;

    typedef enum logic [0:0] {
        REG_CIPHER_KEY = 1'b0
    } reg_index_t;

    localparam logic [7:0] TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [7:0] TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [7:0] TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam logic [7:0] TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    localparam logic [7:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam logic [7:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    localparam logic [1:0] TAB_ROT [RoundCount] = '{
        1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] TAB_S [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
        0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
        15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
        3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
        13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
        13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
        1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
        13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
        3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
        14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
        11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
        10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
        4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
        13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
        6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
        1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
        2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-TAB_IP[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-TAB_FP[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = x[64-TAB_PC1[i]];
        return r;
    endfunction

    function automatic subkey_t perm_pc2(input logic [55:0] x);
        subkey_t r;
        for (int i = 0; i < 48; i++) r[47-i] = x[56-TAB_PC2[i]];
        return r;
    endfunction

    function automatic half_key_t rotl28(input half_key_t x, input logic [1:0] s);
        return (s == 2'd1) ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t sub);
        logic [47:0] x;
        logic [31:0] y;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
        x = x ^ sub;
        for (int b = 0; b < 8; b++)
        begin
            six = x[47-6*b -: 6];
            y[31-4*b -: 4] = TAB_S[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = y[32-TAB_P[i]];
        return p;
    endfunction

endpackage

// ===== sv/des_stream_if.sv =====
// des_stream_if: valid/ready channel carrying des payload
// depends on des_pkg
interface des_stream_if
    import des_pkg::*;
#(
    parameter int unsigned HAS_DIR = 1
);
    logic   valid;
    logic   ready;
    block_t data_block;
    logic   decrypt_select;
    block_t result_block;

    modport source (output valid, output data_block, output decrypt_select,
                    output result_block, input ready);
    modport sink   (input valid, input data_block, input decrypt_select,
                    input result_block, output ready);
endinterface

// ===== sv/des_block_cipher_core.sv =====
// des_block_cipher_core: fully unrolled des pipeline, one round per stage
// depends on des_pkg and des_stream_if
//
// usage
// - key written over the apb port at byte address 0 (64-bit data), reads back
// - blocks enter on in_ch (data_block, decrypt_select), results leave on
//   out_ch (result_block), both valid/ready
// - the subkeys are derived from the key register combinationally; the user
//   must write the key only while the pipeline is empty; the block does not enforce it
// - 17 register stages: initial permutation plus round 1 in the first,
//   one feistel round in each next, the last is the output register
// - accepted blocks pass the 16 round stages, then the output register; one
//   block per cycle throughput while out_ch does not stall
// - a stall on out_ch freezes the run of full stages at the output end; empty
//   stages, and full stages ahead of an empty one, still advance, so bubbles are
//   squeezed out and in_ch stays ready until the whole pipe is full
// - reset clears the key and all stage valid bits
module des_block_cipher_core
    import des_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    des_stream_if.sink   in_ch,
    des_stream_if.source out_ch
);
    logic [63:0] key_reg;
    logic [55:0] cd_w;
    subkey_t     subkey [RoundCount];
    half_key_t   c_w [RoundCount+1];
    half_key_t   d_w [RoundCount+1];

    logic        vld_reg [RoundCount+1];
    logic        dir_reg [RoundCount];
    logic [31:0] l_reg   [RoundCount];
    logic [31:0] r_reg   [RoundCount];
    block_t      out_reg;
    logic        adv     [RoundCount+1];
    logic [63:0] ip_w;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_CIPHER_KEY) ? key_reg : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else if (psel && penable && pwrite && paddr[3] == REG_CIPHER_KEY)
            key_reg <= pwdata;
    end

    assign cd_w   = perm_pc1(key_reg);
    assign c_w[0] = cd_w[55:28];
    assign d_w[0] = cd_w[27:0];
    for (genvar i = 0; i < RoundCount; i++)
    begin : g_key
        assign c_w[i+1]  = rotl28(c_w[i], TAB_ROT[i]);
        assign d_w[i+1]  = rotl28(d_w[i], TAB_ROT[i]);
        assign subkey[i] = perm_pc2({c_w[i+1], d_w[i+1]});
    end

    // stage advance, last stage first
    always_comb
    begin
        adv[RoundCount] = !vld_reg[RoundCount] || out_ch.ready;
        for (int s = RoundCount - 1; s >= 0; s--)
            adv[s] = !vld_reg[s] || adv[s+1];
    end

    assign in_ch.ready   = adv[0];
    assign out_ch.valid  = vld_reg[RoundCount];
    assign out_ch.result_block   = out_reg;
    assign out_ch.data_block     = '0;
    assign out_ch.decrypt_select = 1'b0;
    assign ip_w = perm_ip(in_ch.data_block);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= RoundCount; s++) vld_reg[s] <= 1'b0;
        end
        else
        begin
            if (adv[0]) vld_reg[0] <= in_ch.valid;
            for (int s = 1; s <= RoundCount; s++)
                if (adv[s]) vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dir_reg[0] <= in_ch.decrypt_select;
            l_reg[0]   <= ip_w[31:0];
            r_reg[0]   <= ip_w[63:32] ^ feistel(ip_w[31:0],
                          in_ch.decrypt_select ? subkey[RoundCount-1] : subkey[0]);
        end
        for (int s = 1; s < RoundCount; s++)
            if (adv[s])
            begin
                dir_reg[s] <= dir_reg[s-1];
                l_reg[s]   <= r_reg[s-1];
                r_reg[s]   <= l_reg[s-1] ^ feistel(r_reg[s-1],
                              dir_reg[s-1] ? subkey[RoundCount-1-s] : subkey[s]);
            end
        if (adv[RoundCount])
            out_reg <= perm_fp({r_reg[RoundCount-1], l_reg[RoundCount-1]});
    end
endmodule

// ===== sv/des_checker.sv =====
// des_core_assertions: port-level checks for des_block_cipher_core
// depends on des_pkg; bound into des_block_cipher_core
module des_core_assertions
    import des_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input block_t result_block,
    input logic   pready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_block))
        else $error("result dropped during stall");
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_ready |-> 1'b0)
        else $error("input stalled with empty output stage");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready && !in_ready |=> in_ready)
        else $error("pipe did not advance");
endmodule

bind des_block_cipher_core des_core_assertions u_des_core_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result_block (out_ch.result_block),
    .pready       (pready)
);
